[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int MAX_DIGITS  = 10;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 8;
    localparam int IDX_W       = ROW_W + COL_W;
    localparam int ADDR_W      = 17;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

    // input kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FG   = 2'd0;
    localparam logic [1:0] CFG_BG   = 2'd1;
    localparam logic [1:0] CFG_BASE = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  ASCII_ZERO   = 8'h30;
    localparam logic [15:0] BASE_RESET   = 16'hB800;

    // ceil(2^35 / 10): exact quotient for every 32-bit dividend
    localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT  = 35;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [31:0] number;
        logic [7:0]  new_row;
        logic [7:0]  new_column;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [15:0]       cell_word;
        logic              last_write;
    } t_out_item;

    typedef struct packed {
        logic load;   // take a new dividend
        logic mul;    // reciprocal multiply, quotient registered
        logic step;   // quotient becomes the next dividend
    } t_div_ctrl;

endpackage

[rtl/core/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console writer: characters, decimal numbers and cursor moves
// turned into cell writes of a text buffer.
// ----------------------------------------------------------------------------
// One item is taken at a time; o_in_stall stays high while an item is in work.
// A character goes through one write beat; a newline, a cursor move or an
// unused kind writes nothing and leaves the input open. A number of up to 10
// digits uses the shared divide-by-ten unit for each digit (reciprocal multiply,
// then remainder), then each digit is one write beat.
// Write beats wait while i_out_stall is high; the output register lets the
// next item in while the last beat is still pending.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcw_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(COLUMNS - 1);

    logic [1:0]                  r_state, n_state;
    logic [tcw_pkg::ROW_W-1:0]   r_line, n_line;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::CNT_W-1:0]   r_ndig, n_ndig;
    logic [7:0]                  r_buf [tcw_pkg::MAX_DIGITS];
    logic [3:0]                  r_fg;
    logic [3:0]                  r_bg;
    logic [15:0]                 r_base;
    logic                        r_out_valid;
    tcw_pkg::t_out_item          r_out_data;

    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_push;
    logic [7:0]                  w_push_char;
    tcw_pkg::t_div_ctrl          w_div_ctrl;
    logic [3:0]                  w_digit;
    logic                        w_quot_zero;
    logic [tcw_pkg::ADDR_W-1:0]  w_addr;
    logic [15:0]                 w_word;
    logic [tcw_pkg::COL_W-1:0]   w_new_col;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_new_col = (i_in_data.new_column > 8'(COLUMNS - 1))
                     ? LAST_COL : i_in_data.new_column[tcw_pkg::COL_W-1:0];

    tcw_div10_unit u_div (
        .i_clk       (i_clk),
        .i_ctrl      (w_div_ctrl),
        .i_number    (i_in_data.number),
        .o_digit     (w_digit),
        .o_quot_zero (w_quot_zero)
    );

    tcw_cell_gen #(
        .COLUMNS (COLUMNS)
    ) u_cell (
        .i_line    (r_line),
        .i_col     (r_col),
        .i_base    (r_base),
        .i_fg      (r_fg),
        .i_bg      (r_bg),
        .i_char    (r_buf[0]),
        .o_address (w_addr),
        .o_word    (w_word)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_col       = r_col;
        n_ndig      = r_ndig;
        w_push      = 1'b0;
        w_push_char = i_in_data.char_code;
        w_div_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_in_data.kind == tcw_pkg::KIND_CHAR) begin
                        if (i_in_data.char_code == tcw_pkg::NEWLINE_CODE) begin
                            n_line = r_line + 1'b1;
                            n_col  = '0;
                        end else begin
                            w_push  = 1'b1;
                            n_ndig  = tcw_pkg::CNT_W'(1);
                            n_state = S_EMIT;
                        end
                    end else if (i_in_data.kind == tcw_pkg::KIND_NUMBER) begin
                        w_div_ctrl.load = 1'b1;
                        n_ndig          = '0;
                        n_state         = S_MUL;
                    end else if (i_in_data.kind == tcw_pkg::KIND_CURSOR) begin
                        n_line = i_in_data.new_row;
                        n_col  = w_new_col;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MUL: begin
                w_div_ctrl.mul = 1'b1;
                n_state        = S_REM;
            end
            S_REM: begin
                w_div_ctrl.step = 1'b1;
                w_push          = 1'b1;
                w_push_char     = tcw_pkg::ASCII_ZERO | {4'h0, w_digit};
                n_ndig          = r_ndig + 1'b1;
                if (w_quot_zero ||
                    (r_ndig == tcw_pkg::CNT_W'(tcw_pkg::MAX_DIGITS - 1))) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ndig = r_ndig - 1'b1;
                    if (r_col >= LAST_COL) begin
                        n_line = r_line + 1'b1;
                        n_col  = '0;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    if (r_ndig == tcw_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line      <= '0;
            r_col       <= '0;
            r_ndig      <= '0;
            r_fg        <= '0;
            r_bg        <= '0;
            r_base      <= tcw_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            r_col   <= n_col;
            r_ndig  <= n_ndig;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcw_pkg::CFG_FG:   r_fg   <= i_cfg_data[3:0];
                    tcw_pkg::CFG_BG:   r_bg   <= i_cfg_data[3:0];
                    tcw_pkg::CFG_BASE: r_base <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit stack: digits come least significant first, leave from the top
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[0] <= w_push_char;
            for (int i = 1; i < tcw_pkg::MAX_DIGITS; i++) begin
                r_buf[i] <= r_buf[i-1];
            end
        end else if (w_emit) begin
            for (int i = 0; i < tcw_pkg::MAX_DIGITS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data.write_address <= w_addr;
            r_out_data.cell_word     <= w_word;
            r_out_data.last_write    <= (r_ndig == tcw_pkg::CNT_W'(1));
        end
    end

endmodule

[rtl/core/tcw_div10_unit.sv]
// ----------------------------------------------------------------------------
// tcw_div10_unit
// Shared divide-by-ten unit: one reciprocal multiply and one remainder step.
// ----------------------------------------------------------------------------
module tcw_div10_unit (
    input  logic                i_clk,
    input  tcw_pkg::t_div_ctrl  i_ctrl,
    input  logic [31:0]         i_number,
    output logic [3:0]          o_digit,
    output logic                o_quot_zero
);

    logic [31:0] r_num;
    logic [28:0] r_quot;
    logic [63:0] w_prod;
    logic [31:0] w_quot10;
    logic [31:0] w_rem;

    assign w_prod   = 64'(r_num) * 64'(tcw_pkg::RECIP_TEN);
    assign w_quot10 = {r_quot, 3'b000} + {2'b00, r_quot, 1'b0};
    assign w_rem    = r_num - w_quot10;

    assign o_digit     = w_rem[3:0];
    assign o_quot_zero = (r_quot == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_num <= i_number;
        end else if (i_ctrl.step) begin
            r_num <= 32'(r_quot);
        end
        if (i_ctrl.mul) begin
            r_quot <= w_prod[63:tcw_pkg::RECIP_SHIFT];
        end
    end

endmodule

[rtl/core/tcw_cell_gen.sv]
// ----------------------------------------------------------------------------
// tcw_cell_gen
// Cell address and cell word for the character at the cursor.
// ----------------------------------------------------------------------------
module tcw_cell_gen #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
    input  logic [tcw_pkg::ROW_W-1:0]  i_line,
    input  logic [tcw_pkg::COL_W-1:0]  i_col,
    input  logic [15:0]                i_base,
    input  logic [3:0]                 i_fg,
    input  logic [3:0]                 i_bg,
    input  logic [7:0]                 i_char,
    output logic [tcw_pkg::ADDR_W-1:0] o_address,
    output logic [15:0]                o_word
);

    logic [tcw_pkg::IDX_W-1:0] w_index;

    assign w_index   = tcw_pkg::IDX_W'(i_line) * tcw_pkg::IDX_W'(COLUMNS)
                     + tcw_pkg::IDX_W'(i_col);
    // byte address, two bytes per cell, wraps at 17 bits
    assign o_address = tcw_pkg::ADDR_W'(i_base)
                     + tcw_pkg::ADDR_W'({w_index, 1'b0});
    assign o_word    = {i_bg, i_fg, i_char};

endmodule

[rtl/core/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  tcw_pkg::t_in_item   i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  tcw_pkg::t_out_item  o_out_data
);

    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;

    // reset leaves no beat pending and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset not idle");

    // a printable character keeps the block busy for its write
    a_char_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_data.kind == tcw_pkg::KIND_CHAR)
        && (i_in_data.char_code != tcw_pkg::NEWLINE_CODE) |=> o_in_stall)
        else $error("character accepted without a write phase");

    // items that write nothing leave the input open
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (((i_in_data.kind == tcw_pkg::KIND_CHAR)
        && (i_in_data.char_code == tcw_pkg::NEWLINE_CODE))
        || (i_in_data.kind == tcw_pkg::KIND_CURSOR)) |=> !o_in_stall)
        else $error("block busy after an item with no write");

    // a number needs at least a divide and an emit
    a_number_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_data.kind == tcw_pkg::KIND_NUMBER) |=> o_in_stall ##1 o_in_stall)
        else $error("number finished too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
